@@ hw/rtl/vip_pkg.sv @@
// Shared types and constants for the version-information parameter parser.
// Depends on nothing; used by the parser top level, its result queue and checker.
package vip_pkg;

	// Field widths fixed by the item formats
	localparam int ID_W    = 62;
	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 32;
	localparam int IDX_W   = 5;
	localparam int ERR_W   = 3;
	localparam int CONS_W  = 10;
	localparam int KIND_W  = 2;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_CHOSEN = 2'd0;
	localparam logic [KIND_W-1:0] KIND_AVAIL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
	localparam logic [ERR_W-1:0] ERR_ID        = 3'd1;
	localparam logic [ERR_W-1:0] ERR_BAD_LEN   = 3'd2;
	localparam logic [ERR_W-1:0] ERR_TOO_MANY  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd4;

	// Default identifier and minimum value length
	localparam logic [ID_W-1:0] DEFAULT_PARAM_ID = 62'd17;
	localparam logic [ID_W-1:0] MIN_VALUE_LEN    = 62'd4;

	// Result queue geometry
	localparam int RES_FIFO_DEPTH = 4;
	localparam int RES_PTR_W      = 2;
	localparam int RES_CNT_W      = 3;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic [WORD_W-1:0] version_word;
		logic [IDX_W-1:0]  version_index;
		logic [ERR_W-1:0]  error_code;
		logic [CONS_W-1:0] consumed_bytes;
		logic              last_of_run;
	} result_t;

endpackage

@@ hw/rtl/vip_result_fifo.sv @@
// Small result queue for the parser: takes up to two result items per cycle,
// hands out one per cycle on a valid/ready channel. Depends on vip_pkg.
module vip_result_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  vip_pkg::result_t push_item0,
	input  vip_pkg::result_t push_item1,
	output logic             room_two,
	output logic             out_valid,
	input  logic             out_ready,
	output vip_pkg::result_t out_item
);

	vip_pkg::result_t                  mem_q [vip_pkg::RES_FIFO_DEPTH];
	logic [vip_pkg::RES_PTR_W-1:0]     wr_ptr_q;
	logic [vip_pkg::RES_PTR_W-1:0]     rd_ptr_q;
	logic [vip_pkg::RES_CNT_W-1:0]     count_q;
	logic [vip_pkg::RES_PTR_W-1:0]     wr_ptr_p1;
	logic                              pop;

	assign wr_ptr_p1 = wr_ptr_q + vip_pkg::RES_PTR_W'(1);
	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign room_two  = (count_q <= vip_pkg::RES_CNT_W'(vip_pkg::RES_FIFO_DEPTH - 2));

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_item0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_p1] <= push_item1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + vip_pkg::RES_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + vip_pkg::RES_PTR_W'(1);
			end
			count_q <= count_q + vip_pkg::RES_CNT_W'(push_n) - vip_pkg::RES_CNT_W'(pop);
		end
	end

endmodule

@@ hw/rtl/version_info_parser.sv @@
// Top level of the version-information transport parameter parser.
// Depends on vip_pkg and vip_result_fifo.
//
// Usage:
//   in channel  (in_valid/in_ready/in_item): one buffer byte per item plus an
//     end-of-buffer flag. One item is taken per cycle when the result queue
//     has room for two results.
//   out channel (out_valid/out_ready/out_item): result items in order: the
//     chosen version, the available versions, then a done or error item with
//     last_of_run set. An item may yield none, one or two results (final word
//     plus done). On an error the consumer drops the words of that run.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes the expected parameter
//     identifier; always ready, write only while no parse is in flight.
// Latency: results of an item taken at one edge are offered from the next
//   cycle on. Throughput: one item per cycle; the parse state loop and the
//   four-entry result queue set that, and the queue drains one result a cycle.
// Reset: parser returns to awaiting the identifier, queue empties, identifier
//   register goes to 17. A stalled receiver fills the queue; in_ready drops
//   once fewer than two queue slots are free and rises as results drain.
module version_info_parser #(
	parameter int MAX_AVAILABLE = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [vip_pkg::ID_W-1:0]     cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  vip_pkg::in_item_t            in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output vip_pkg::result_t             out_item
);

	localparam int WIDX_W = $clog2(MAX_AVAILABLE + 2);
	localparam int VLEN_W = $clog2(4 * (MAX_AVAILABLE + 1) + 1);
	localparam logic [vip_pkg::ID_W-1:0] MAX_VLEN = vip_pkg::ID_W'(4 * (MAX_AVAILABLE + 1));

	// parse phases
	localparam logic [2:0] PH_ID_FIRST  = 3'd0;
	localparam logic [2:0] PH_ID_CONT   = 3'd1;
	localparam logic [2:0] PH_LEN_FIRST = 3'd2;
	localparam logic [2:0] PH_LEN_CONT  = 3'd3;
	localparam logic [2:0] PH_VALUE     = 3'd4;
	localparam logic [2:0] PH_SKIP      = 3'd5;

	// state registers
	logic [2:0]                  phase_q,  phase_d;
	logic [vip_pkg::ID_W-1:0]    acc_q,    acc_d;
	logic [2:0]                  vleft_q,  vleft_d;
	logic [4:0]                  hdr_q,    hdr_d;
	logic [VLEN_W-1:0]           vbytes_q, vbytes_d;
	logic [vip_pkg::WORD_W-1:0]  shift_q,  shift_d;
	logic [WIDX_W-1:0]           widx_q,   widx_d;
	logic [vip_pkg::ID_W-1:0]    cfg_id_q;

	// step signals
	logic                        fire;
	logic [vip_pkg::BYTE_W-1:0]  b;
	logic                        eob;
	logic                        first;
	logic [vip_pkg::ID_W-1:0]    acc_next;
	logic [2:0]                  vleft_next;
	logic [4:0]                  hdr_next;
	logic [VLEN_W-1:0]           vbytes_next;
	logic [vip_pkg::WORD_W-1:0]  shift_next;
	logic [WIDX_W-1:0]           widx_inc;
	logic [WIDX_W-1:0]           widx_m1;
	logic [vip_pkg::CONS_W-1:0]  consumed;
	logic                        term;
	logic [1:0]                  n_res;
	logic [1:0]                  push_n;
	vip_pkg::result_t            res0, res1;

	function automatic vip_pkg::result_t mk_result(
		input logic [vip_pkg::KIND_W-1:0] kind,
		input logic [vip_pkg::WORD_W-1:0] word,
		input logic [vip_pkg::IDX_W-1:0]  idx,
		input logic [vip_pkg::ERR_W-1:0]  err,
		input logic [vip_pkg::CONS_W-1:0] cons,
		input logic                       last
	);
		vip_pkg::result_t r;
		r.result_kind    = kind;
		r.version_word   = word;
		r.version_index  = idx;
		r.error_code     = err;
		r.consumed_bytes = cons;
		r.last_of_run    = last;
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign fire      = in_valid && in_ready;
	assign b         = in_item.data_byte;
	assign eob       = in_item.end_of_buffer;

	// varint byte: first byte sets length from the 2-bit prefix
	assign first    = (phase_q == PH_ID_FIRST) || (phase_q == PH_LEN_FIRST);
	assign hdr_next = ((phase_q == PH_ID_FIRST) ? 5'd0 : hdr_q) + 5'd1;
	assign acc_next = first ? {{(vip_pkg::ID_W - 6){1'b0}}, b[5:0]}
	                        : {acc_q[vip_pkg::ID_W-9:0], b};

	always_comb begin
		if (first) begin
			case (b[7:6])
				2'd0:    vleft_next = 3'd0;
				2'd1:    vleft_next = 3'd1;
				2'd2:    vleft_next = 3'd3;
				default: vleft_next = 3'd7;
			endcase
		end else begin
			vleft_next = vleft_q - 3'(vleft_q != 3'd0);
		end
	end

	// value bytes: shift in, count down, word every four bytes
	assign vbytes_next = vbytes_q - VLEN_W'(vbytes_q != '0);
	assign shift_next  = {shift_q[vip_pkg::WORD_W-9:0], b};
	assign widx_inc    = widx_q + WIDX_W'(1);
	assign widx_m1     = widx_q - WIDX_W'(1);
	assign consumed    = vip_pkg::CONS_W'(hdr_q) + vip_pkg::CONS_W'({widx_inc, 2'b00});

	// one parse step
	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		vleft_d  = vleft_q;
		hdr_d    = hdr_q;
		vbytes_d = vbytes_q;
		shift_d  = shift_q;
		widx_d   = widx_q;
		term     = 1'b0;
		n_res    = 2'd0;
		res0     = '0;
		res1     = '0;

		case (phase_q)
			PH_ID_FIRST, PH_ID_CONT: begin
				hdr_d   = hdr_next;
				acc_d   = acc_next;
				vleft_d = vleft_next;
				if (vleft_next == 3'd0) begin
					if (acc_next != cfg_id_q) begin
						res0  = mk_result(vip_pkg::KIND_ERROR, '0, '0, vip_pkg::ERR_ID, '0, 1'b1);
						n_res = 2'd1;
						term  = 1'b1;
					end else begin
						phase_d = PH_LEN_FIRST;
					end
				end else begin
					phase_d = PH_ID_CONT;
				end
			end
			PH_LEN_FIRST, PH_LEN_CONT: begin
				hdr_d   = hdr_next;
				acc_d   = acc_next;
				vleft_d = vleft_next;
				if (vleft_next == 3'd0) begin
					if (acc_next < vip_pkg::MIN_VALUE_LEN || acc_next[1:0] != 2'b00) begin
						res0  = mk_result(vip_pkg::KIND_ERROR, '0, '0,
						                  vip_pkg::ERR_BAD_LEN, '0, 1'b1);
						n_res = 2'd1;
						term  = 1'b1;
					end else if (acc_next > MAX_VLEN) begin
						res0  = mk_result(vip_pkg::KIND_ERROR, '0, '0,
						                  vip_pkg::ERR_TOO_MANY, '0, 1'b1);
						n_res = 2'd1;
						term  = 1'b1;
					end else begin
						vbytes_d = acc_next[VLEN_W-1:0];
						shift_d  = '0;
						widx_d   = '0;
						phase_d  = PH_VALUE;
					end
				end else begin
					phase_d = PH_LEN_CONT;
				end
			end
			PH_VALUE: begin
				vbytes_d = vbytes_next;
				shift_d  = shift_next;
				if (vbytes_next[1:0] == 2'b00) begin
					if (widx_q == '0) begin
						res0 = mk_result(vip_pkg::KIND_CHOSEN, shift_next, '0,
						                 vip_pkg::ERR_NONE, '0, 1'b0);
					end else begin
						res0 = mk_result(vip_pkg::KIND_AVAIL, shift_next,
						                 vip_pkg::IDX_W'(widx_m1), vip_pkg::ERR_NONE, '0, 1'b0);
					end
					n_res   = 2'd1;
					widx_d  = widx_inc;
					shift_d = '0;
					if (vbytes_next == '0) begin
						res1  = mk_result(vip_pkg::KIND_DONE, '0, '0, vip_pkg::ERR_NONE,
						                  consumed, 1'b1);
						n_res = 2'd2;
						term  = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		// early end of buffer replaces whatever this byte produced, unless it ended the run
		if (!term && phase_q != PH_SKIP && eob) begin
			res0  = mk_result(vip_pkg::KIND_ERROR, '0, '0, vip_pkg::ERR_TRUNCATED, '0, 1'b1);
			n_res = 2'd1;
			term  = 1'b1;
		end
		if (term || phase_q == PH_SKIP) begin
			phase_d = eob ? PH_ID_FIRST : PH_SKIP;
		end
	end

	assign push_n = fire ? n_res : 2'd0;

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ID_FIRST;
			acc_q    <= '0;
			vleft_q  <= '0;
			hdr_q    <= '0;
			vbytes_q <= '0;
			shift_q  <= '0;
			widx_q   <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			vleft_q  <= vleft_d;
			hdr_q    <= hdr_d;
			vbytes_q <= vbytes_d;
			shift_q  <= shift_d;
			widx_q   <= widx_d;
		end
	end

	// identifier register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_id_q <= vip_pkg::DEFAULT_PARAM_ID;
		end else if (cfg_valid && cfg_ready) begin
			cfg_id_q <= cfg_data;
		end
	end

	vip_result_fifo u_result_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_item0 (res0),
		.push_item1 (res1),
		.room_two   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

@@ hw/rtl/vip_checker.sv @@
// Port-level checks for version_info_parser, attached by the bind below.
// Depends on vip_pkg; watches the top level's ports only.
module vip_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input vip_pkg::result_t           out_item
);

	logic                              out_fire;
	logic                              mid_run_q;
	logic [vip_pkg::KIND_W-1:0]        prev_kind_q;
	logic [vip_pkg::IDX_W-1:0]         prev_idx_q;

	assign out_fire = out_valid && out_ready;

	// track the last accepted result item of the current run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_run_q   <= 1'b0;
			prev_kind_q <= vip_pkg::KIND_DONE;
			prev_idx_q  <= '0;
		end else if (out_fire) begin
			mid_run_q   <= !out_item.last_of_run;
			prev_kind_q <= out_item.result_kind;
			prev_idx_q  <= out_item.version_index;
		end
	end

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	// results appear only after an input item was taken
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(in_valid && in_ready))
		else $error("result item without an input item");

	// an empty result side never blocks input
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no pending result");

	// available versions follow the chosen version with rising index
	a_avail_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && out_item.result_kind == vip_pkg::KIND_AVAIL |->
			mid_run_q &&
			((prev_kind_q == vip_pkg::KIND_CHOSEN && out_item.version_index == '0) ||
			 (prev_kind_q == vip_pkg::KIND_AVAIL &&
			  out_item.version_index == prev_idx_q + vip_pkg::IDX_W'(1))))
		else $error("available version out of order");

	// done closes a run that emitted words
	a_done_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && out_item.result_kind == vip_pkg::KIND_DONE |->
			mid_run_q && out_item.last_of_run &&
			(prev_kind_q == vip_pkg::KIND_CHOSEN || prev_kind_q == vip_pkg::KIND_AVAIL))
		else $error("done item without preceding words");

endmodule

bind version_info_parser vip_checker u_vip_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for version_info_parser: directed table, then random buffers.
// Depends on vip_pkg and the parser RTL; expected results come from a local parser model.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_AVAIL = 16;

	// Parser phases of the local model
	localparam logic [2:0] PH_ID_FIRST  = 3'd0;
	localparam logic [2:0] PH_ID_CONT   = 3'd1;
	localparam logic [2:0] PH_LEN_FIRST = 3'd2;
	localparam logic [2:0] PH_LEN_CONT  = 3'd3;
	localparam logic [2:0] PH_VALUE     = 3'd4;
	localparam logic [2:0] PH_SKIP      = 3'd5;

	// One directed row: a byte, its end flag, and a typed-in error code
	// (ERR_NONE means the model decides)
	typedef struct packed {
		logic [vip_pkg::BYTE_W-1:0] data_byte;
		logic                       end_of_buffer;
		logic [vip_pkg::ERR_W-1:0]  typed_err;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [vip_pkg::ID_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	vip_pkg::in_item_t in_item;
	logic out_valid;
	logic out_ready = 1'b0;
	vip_pkg::result_t out_item;

	bit calm;
	int failures;
	int n_items;

	// Parser model state
	logic [vip_pkg::ID_W-1:0]   param_id;
	logic [2:0]                 cur_phase;
	logic [vip_pkg::ID_W-1:0]   acc;
	logic [2:0]                 vint_left;
	logic [4:0]                 hdr_count;
	logic [9:0]                 val_left;
	logic [vip_pkg::WORD_W-1:0] word_acc;
	logic [vip_pkg::IDX_W-1:0]  word_count;

	vip_pkg::result_t step_results[$];
	vip_pkg::result_t version_results[$];
	vip_pkg::in_item_t frame[$];

	version_info_parser #(.MAX_AVAILABLE(MAX_AVAIL)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always #10ns clk = ~clk;

	// Run limit
	initial begin
		#5ms;
		$display("version_info_parser verification failed");
		$finish;
	end

	// Receiver stalls
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 16);
	end

	function automatic void add_result(logic [vip_pkg::KIND_W-1:0] k,
			logic [vip_pkg::WORD_W-1:0] w, logic [vip_pkg::IDX_W-1:0] ix,
			logic [vip_pkg::ERR_W-1:0] e, logic [vip_pkg::CONS_W-1:0] c, logic l);
		vip_pkg::result_t r;
		r.result_kind    = k;
		r.version_word   = w;
		r.version_index  = ix;
		r.error_code     = e;
		r.consumed_bytes = c;
		r.last_of_run    = l;
		step_results.push_back(r);
	endfunction

	// One varint byte; returns 1 when the varint is complete
	function automatic bit take_varint_byte(bit first, logic [7:0] b);
		hdr_count = hdr_count + 5'd1;
		if (first) begin
			acc       = vip_pkg::ID_W'(b[5:0]);
			vint_left = 3'((1 << b[7:6]) - 1);
		end else begin
			acc = {acc[vip_pkg::ID_W-9:0], b};
			if (vint_left != 3'd0)
				vint_left = vint_left - 3'd1;
		end
		return vint_left == 3'd0;
	endfunction

	// Advance the model by one byte; results land in step_results
	function automatic void parse_byte(logic [7:0] b, logic eob);
		bit term;
		bit was_skip;
		logic [vip_pkg::ID_W-1:0] vlen;
		step_results.delete();
		term     = 1'b0;
		was_skip = (cur_phase == PH_SKIP);
		case (cur_phase)
			PH_ID_FIRST, PH_ID_CONT: begin
				if (cur_phase == PH_ID_FIRST)
					hdr_count = '0;
				if (take_varint_byte(cur_phase == PH_ID_FIRST, b)) begin
					if (acc != param_id) begin
						add_result(vip_pkg::KIND_ERROR, '0, '0, vip_pkg::ERR_ID, '0, 1'b1);
						term = 1'b1;
					end else begin
						cur_phase = PH_LEN_FIRST;
					end
				end else begin
					cur_phase = PH_ID_CONT;
				end
			end
			PH_LEN_FIRST, PH_LEN_CONT: begin
				if (take_varint_byte(cur_phase == PH_LEN_FIRST, b)) begin
					vlen = acc;
					if (vlen < vip_pkg::MIN_VALUE_LEN || vlen[1:0] != 2'd0) begin
						add_result(vip_pkg::KIND_ERROR, '0, '0, vip_pkg::ERR_BAD_LEN, '0, 1'b1);
						term = 1'b1;
					end else if ((vlen >> 2) - 1 > vip_pkg::ID_W'(MAX_AVAIL)) begin
						add_result(vip_pkg::KIND_ERROR, '0, '0, vip_pkg::ERR_TOO_MANY, '0, 1'b1);
						term = 1'b1;
					end else begin
						val_left   = vlen[9:0];
						word_acc   = '0;
						word_count = '0;
						cur_phase  = PH_VALUE;
					end
				end else begin
					cur_phase = PH_LEN_CONT;
				end
			end
			PH_VALUE: begin
				word_acc = {word_acc[vip_pkg::WORD_W-9:0], b};
				if (val_left != 10'd0)
					val_left = val_left - 10'd1;
				if (val_left[1:0] == 2'd0) begin
					if (word_count == '0)
						add_result(vip_pkg::KIND_CHOSEN, word_acc, '0, vip_pkg::ERR_NONE,
							'0, 1'b0);
					else
						add_result(vip_pkg::KIND_AVAIL, word_acc, word_count - 5'd1,
							vip_pkg::ERR_NONE, '0, 1'b0);
					word_count = word_count + 5'd1;
					word_acc   = '0;
					if (val_left == 10'd0) begin
						add_result(vip_pkg::KIND_DONE, '0, '0, vip_pkg::ERR_NONE,
							vip_pkg::CONS_W'(hdr_count) + vip_pkg::CONS_W'(word_count) * 10'd4,
							1'b1);
						term = 1'b1;
					end
				end
			end
			default: ;
		endcase
		// early end of buffer drops whatever this byte produced, unless it ended the run
		if (!term && !was_skip && eob) begin
			step_results.delete();
			add_result(vip_pkg::KIND_ERROR, '0, '0, vip_pkg::ERR_TRUNCATED, '0, 1'b1);
			term = 1'b1;
		end
		if (term || was_skip)
			cur_phase = eob ? PH_ID_FIRST : PH_SKIP;
	endfunction

	// Drive one item, wait for acceptance, record what it should produce
	task automatic send_item(logic [7:0] b, logic eob, logic [vip_pkg::ERR_W-1:0] typed_err);
		bit counted;
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid              <= 1'b1;
		in_item.data_byte     <= b;
		in_item.end_of_buffer <= eob;
		do @(posedge clk); while (!in_ready);
		counted = (cur_phase != PH_SKIP);
		parse_byte(b, eob);
		if (typed_err != vip_pkg::ERR_NONE) begin
			step_results.delete();
			add_result(vip_pkg::KIND_ERROR, '0, '0, typed_err, '0, 1'b1);
		end
		foreach (step_results[i])
			version_results.push_back(step_results[i]);
		if (counted)
			n_items++;
	endtask

	// Stop sending and let every expected result arrive
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (version_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_param_id(logic [vip_pkg::ID_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		param_id = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void put_byte(logic [7:0] b);
		vip_pkg::in_item_t it;
		it.data_byte     = b;
		it.end_of_buffer = 1'b0;
		frame.push_back(it);
	endfunction

	// Varint encoding, shortest form mostly, sometimes a longer one
	function automatic void put_varint(logic [vip_pkg::ID_W-1:0] v);
		int lg;
		int nbytes;
		logic [63:0] w;
		if (v < 62'd64)
			lg = 0;
		else if (v < 62'd16384)
			lg = 1;
		else if (v < 62'd1073741824)
			lg = 2;
		else
			lg = 3;
		if ($urandom_range(0, 3) == 0)
			lg = $urandom_range(lg, 3);
		nbytes = 1 << lg;
		w = 64'(v) | (64'(lg) << (8 * nbytes - 2));
		for (int i = nbytes - 1; i >= 0; i--)
			put_byte(w[8*i +: 8]);
	endfunction

	// Build one random buffer: mostly well formed, the rest broken or noise
	function automatic void build_frame();
		int pick;
		int nwords;
		int cut;
		logic [vip_pkg::ID_W-1:0] id_val;
		logic [vip_pkg::ID_W-1:0] vlen;
		frame.delete();
		pick = $urandom_range(0, 99);
		if (pick >= 95) begin
			nwords = $urandom_range(1, 12);
			for (int i = 0; i < nwords; i++) begin
				put_byte(8'($urandom_range(0, 255)));
				frame[i].end_of_buffer = ($urandom_range(0, 5) == 0);
			end
			frame[frame.size()-1].end_of_buffer = 1'b1;
			return;
		end
		id_val = param_id;
		if (pick >= 60 && pick < 70)
			id_val = param_id ^ (62'd1 << $urandom_range(0, vip_pkg::ID_W - 1));
		nwords = ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_AVAIL + 1)
			: $urandom_range(1, 4);
		vlen = vip_pkg::ID_W'(4 * nwords);
		if (pick >= 70 && pick < 78) begin
			vlen = ($urandom_range(0, 3) == 0) ? vip_pkg::ID_W'({$urandom, $urandom})
				: vip_pkg::ID_W'($urandom_range(0, 99));
			if (vlen >= vip_pkg::MIN_VALUE_LEN && vlen[1:0] == 2'd0)
				vlen = vlen + 62'd1;
		end else if (pick >= 78 && pick < 85) begin
			vlen = ($urandom_range(0, 3) == 0)
				? (vip_pkg::ID_W'({$urandom, $urandom}) & ~62'd3) | 62'h100
				: vip_pkg::ID_W'(4 * (MAX_AVAIL + 2 + $urandom_range(0, 200)));
		end
		put_varint(id_val);
		put_varint(vlen);
		if (pick < 60 || pick >= 85) begin
			for (int i = 0; i < 4 * nwords; i++)
				put_byte(8'($urandom_range(0, 255)));
		end
		if (pick >= 85) begin
			// truncated: buffer ends before the last value byte
			cut = $urandom_range(0, frame.size() - 2);
			frame = frame[0:cut];
		end else begin
			nwords = $urandom_range(0, 3);
			for (int i = 0; i < nwords; i++)
				put_byte(8'($urandom_range(0, 255)));
		end
		frame[frame.size()-1].end_of_buffer = 1'b1;
	endfunction

	// Result checker
	always @(posedge clk) begin
		vip_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (version_results.size() == 0) begin
				$error("unexpected result item %p", out_item);
				failures++;
			end else begin
				want = version_results.pop_front();
				if (out_item.result_kind !== want.result_kind) begin
					$error("result_kind: expected %0d, got %0d",
						want.result_kind, out_item.result_kind);
					failures++;
				end
				if (out_item.version_word !== want.version_word) begin
					$error("version_word: expected %h, got %h",
						want.version_word, out_item.version_word);
					failures++;
				end
				if (out_item.version_index !== want.version_index) begin
					$error("version_index: expected %0d, got %0d",
						want.version_index, out_item.version_index);
					failures++;
				end
				if (out_item.error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d",
						want.error_code, out_item.error_code);
					failures++;
				end
				if (out_item.consumed_bytes !== want.consumed_bytes) begin
					$error("consumed_bytes: expected %0d, got %0d",
						want.consumed_bytes, out_item.consumed_bytes);
					failures++;
				end
				if (out_item.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %0d, got %0d",
						want.last_of_run, out_item.last_of_run);
					failures++;
				end
			end
		end
	end

	// Main sequence
	initial begin
		logic [vip_pkg::ID_W-1:0] id_plan [10];
		dir_row_t directed [22];
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_item   = '0;
		calm      = 1'b0;
		failures  = 0;
		n_items   = 0;

		param_id   = vip_pkg::DEFAULT_PARAM_ID;
		cur_phase  = PH_ID_FIRST;
		acc        = '0;
		vint_left  = '0;
		hdr_count  = '0;
		val_left   = '0;
		word_acc   = '0;
		word_count = '0;

		directed = '{
			// one word, completes on the buffer's last byte
			'{8'h11, 1'b0, vip_pkg::ERR_NONE}, '{8'h04, 1'b0, vip_pkg::ERR_NONE},
			'{8'hFF, 1'b0, vip_pkg::ERR_NONE}, '{8'hFF, 1'b0, vip_pkg::ERR_NONE},
			'{8'hFF, 1'b0, vip_pkg::ERR_NONE}, '{8'hFF, 1'b1, vip_pkg::ERR_NONE},
			// id mismatch, then trailing bytes up to end of buffer
			'{8'h12, 1'b0, vip_pkg::ERR_ID}, '{8'hAA, 1'b0, vip_pkg::ERR_NONE},
			'{8'h55, 1'b1, vip_pkg::ERR_NONE},
			// length below four
			'{8'h11, 1'b0, vip_pkg::ERR_NONE}, '{8'h03, 1'b1, vip_pkg::ERR_BAD_LEN},
			// length 72 in two bytes: one version too many
			'{8'h11, 1'b0, vip_pkg::ERR_NONE}, '{8'h40, 1'b0, vip_pkg::ERR_NONE},
			'{8'h48, 1'b1, vip_pkg::ERR_TOO_MANY},
			// buffer ends on the byte that completes the chosen version
			'{8'h11, 1'b0, vip_pkg::ERR_NONE}, '{8'h08, 1'b0, vip_pkg::ERR_NONE},
			'{8'h00, 1'b0, vip_pkg::ERR_NONE}, '{8'h00, 1'b0, vip_pkg::ERR_NONE},
			'{8'h00, 1'b0, vip_pkg::ERR_NONE}, '{8'h01, 1'b1, vip_pkg::ERR_TRUNCATED},
			// buffer ends inside the identifier varint
			'{8'h51, 1'b1, vip_pkg::ERR_TRUNCATED},
			// one-byte buffer with a wrong identifier
			'{8'h00, 1'b1, vip_pkg::ERR_ID}
		};

		id_plan = '{vip_pkg::DEFAULT_PARAM_ID, 62'd0, 62'd63, 62'd64, 62'd16383, 62'd16384,
			62'd1073741823, 62'd1073741824, {vip_pkg::ID_W{1'b1}},
			vip_pkg::ID_W'({$urandom, $urandom})};

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_item(directed[i].data_byte, directed[i].end_of_buffer, directed[i].typed_err);
		wait_drained();

		// Random buffers under each identifier setting; one setting runs with no idling
		foreach (id_plan[p]) begin
			write_param_id(id_plan[p]);
			calm = (p == 4);
			n_items = 0;
			while (n_items < 195) begin
				build_frame();
				foreach (frame[i])
					send_item(frame[i].data_byte, frame[i].end_of_buffer, vip_pkg::ERR_NONE);
			end
			calm = 1'b0;
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (version_results.size() != 0) begin
			$error("%0d expected results never arrived", version_results.size());
			failures++;
		end
		if (failures == 0)
			$display("version_info_parser verification clean");
		else
			$display("version_info_parser verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/vip_pkg.sv
hw/rtl/vip_result_fifo.sv
hw/rtl/version_info_parser.sv
hw/rtl/vip_checker.sv
tb/tb_top.sv
